/* rtl/core/wsfp_pkg.sv */
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types, character codes and arithmetic helpers for the wind sentence
// field parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_W      = 8'h57;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_D      = 8'h44;

    // Keyword length and acceptance limits
    localparam logic [2:0]  KEYWORD_LEN    = 3'd5;
    localparam int          MIN_LINE_BYTES = 10;
    localparam logic [1:0]  FRAC_MAX       = 2'd3;
    localparam logic [1:0]  FIELDS_MAX     = 2'd2;
    localparam logic [23:0] MAG_MAX        = 24'd8388607;

    // Scan state of the current line (all clear at line start)
    typedef struct packed {
        logic [2:0]  match_progress;
        logic        keyword_seen;
        logic        scan_ended;
        logic [1:0]  field_index;
        logic [23:0] magnitude;
        logic        negative_seen;
        logic [1:0]  fraction_digits;
        logic        in_fraction;
        logic [23:0] pending_direction;
    } line_state_t;

    // One result item
    typedef struct packed {
        logic [23:0] direction_milli;
        logic [23:0] speed_milli;
        logic        updated;
        logic        reading_present;
    } result_t;

    // Accumulator after one digit
    typedef struct packed {
        logic [23:0] magnitude;
        logic [1:0]  fraction_digits;
    } digit_result_t;

    // Character of "WIND," at a given match position
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CHAR_W;
            3'd1:    ch = CHAR_I;
            3'd2:    ch = CHAR_N;
            3'd3:    ch = CHAR_D;
            3'd4:    ch = CHAR_COMMA;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    // Fold one decimal digit into a thousandths magnitude, saturating
    function automatic digit_result_t add_digit(input logic [23:0] mag,
                                                input logic [3:0]  digit,
                                                input logic        in_fraction,
                                                input logic [1:0]  frac);
        digit_result_t res;
        logic [27:0]   sum;
        logic [6:0]    scale;
        sum   = {4'd0, mag};
        scale = 7'd1;
        res.fraction_digits = frac;
        if (!in_fraction) begin
            sum = {4'd0, mag} * 28'd10 + 28'(digit) * 28'd1000;
        end else if (frac < FRAC_MAX) begin
            case (frac)
                2'd0:    scale = 7'd100;
                2'd1:    scale = 7'd10;
                default: scale = 7'd1;
            endcase
            sum = {4'd0, mag} + 28'(digit) * 28'(scale);
            res.fraction_digits = frac + 2'd1;
        end
        res.magnitude = (sum > 28'(MAG_MAX)) ? MAG_MAX : sum[23:0];
        return res;
    endfunction

    // Two's complement value of the open field
    function automatic logic [23:0] signed_value(input line_state_t ln);
        return ln.negative_seen ? (~ln.magnitude + 24'd1) : ln.magnitude;
    endfunction

endpackage

/* rtl/core/wind_sentence_field_parser.sv */
// ----------------------------------------------------------------------------
// wind_sentence_field_parser
// Scans a received byte stream for "WIND," lines and reports the held wind
// direction and speed, in thousandths, at every newline.
// ----------------------------------------------------------------------------
// Throughput is one byte per cycle. A byte is captured in an input register
// and folded into the line state at the next clock edge unless it is a
// stalled newline; a newline's result is loaded into the result register
// at the edge that folds it in, then shows on the m_ side. The input side
// stalls only when a newline is waiting and the result register still holds
// a result that has not been taken; all other bytes pass freely. The digit
// accumulate (multiply by ten, add, saturate) is combinational and feeds
// the line state register.
module wind_sentence_field_parser #(
    parameter int LINE_CAPACITY = 80
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_direction_milli,
    output logic signed [23:0] m_speed_milli,
    output logic               m_updated,
    output logic               m_reading_present
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              is_newline;
    logic              out_ready;
    logic              proc_fire;
    wsfp_pkg::result_t scan_result;
    wsfp_pkg::result_t out_result;

    // Process the held byte unless it is a newline blocked by a full output
    assign is_newline = (in_byte_reg == wsfp_pkg::CHAR_NL);
    assign proc_fire  = in_valid_reg && (!is_newline || out_ready);
    assign s_ready    = !in_valid_reg || proc_fire;

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Line scanner
    wsfp_scan #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (proc_fire),
        .rx_byte (in_byte_reg),
        .result  (scan_result)
    );

    // Result register
    wsfp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (proc_fire && is_newline),
        .result     (scan_result),
        .load_ready (out_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (out_result)
    );

    assign m_direction_milli = out_result.direction_milli;
    assign m_speed_milli     = out_result.speed_milli;
    assign m_updated         = out_result.updated;
    assign m_reading_present = out_result.reading_present;

`ifndef NO_ASSERTIONS
    // Presence flag agrees with the reported values
    a_present_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reading_present) |->
            (m_direction_milli == 24'sd0 && m_speed_milli == 24'sd0))
        else $error("reading_present low with nonzero held values");

    // A stalled byte stays in the input register unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost while stalled");

    // A blocked newline backpressures the input side
    a_nl_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && in_valid_reg && is_newline) |-> !s_ready)
        else $error("input accepted while newline result is blocked");
`endif

endmodule

/* rtl/core/wsfp_scan.sv */
// ----------------------------------------------------------------------------
// wsfp_scan
// Per-byte line scanner: keyword match, field accumulation, and the held
// direction and speed. One byte is folded in per enabled cycle.
// ----------------------------------------------------------------------------
module wsfp_scan #(
    parameter int LINE_CAPACITY = 80
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               enable,
    input  logic [7:0]         rx_byte,
    output wsfp_pkg::result_t  result
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);

    wsfp_pkg::line_state_t line_reg, line_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [23:0]           held_dir_reg, held_dir_next;
    logic [23:0]           held_speed_reg, held_speed_next;

    // Next line state and result for the byte at the input
    always_comb begin
        wsfp_pkg::line_state_t   ln;
        wsfp_pkg::digit_result_t dg;
        logic [CNT_W-1:0]        cnt;
        logic                    accept;
        logic [23:0]             hd;
        logic [23:0]             hs;

        ln     = line_reg;
        cnt    = count_reg;
        hd     = held_dir_reg;
        hs     = held_speed_reg;
        dg     = '0;

        // '$' restarts the line, then is counted as an ordinary byte
        if (rx_byte == wsfp_pkg::CHAR_DOLLAR) begin
            ln  = '0;
            cnt = '0;
        end

        // Only the first LINE_CAPACITY-1 bytes of a line are counted and scanned
        if (cnt < CNT_W'(LINE_CAPACITY - 1)) begin
            cnt = cnt + CNT_W'(1);
            if (!ln.scan_ended) begin
                if (!ln.keyword_seen) begin
                    // keyword search
                    if (rx_byte == wsfp_pkg::CHAR_NUL) begin
                        ln.scan_ended = 1'b1;
                    end else if (rx_byte == wsfp_pkg::keyword_char(ln.match_progress)) begin
                        ln.match_progress = ln.match_progress + 3'd1;
                        if (ln.match_progress >= wsfp_pkg::KEYWORD_LEN) begin
                            ln.keyword_seen   = 1'b1;
                            ln.match_progress = wsfp_pkg::KEYWORD_LEN;
                        end
                    end else begin
                        ln.match_progress = (rx_byte == wsfp_pkg::CHAR_W) ? 3'd1 : 3'd0;
                    end
                end else if (rx_byte == wsfp_pkg::CHAR_NUL ||
                             rx_byte == wsfp_pkg::CHAR_STAR) begin
                    ln.scan_ended = 1'b1;
                end else if (ln.field_index < wsfp_pkg::FIELDS_MAX) begin
                    // field scan
                    if (rx_byte == wsfp_pkg::CHAR_COMMA) begin
                        if (ln.field_index == 2'd0) begin
                            ln.pending_direction = wsfp_pkg::signed_value(ln);
                            ln.magnitude         = '0;
                            ln.negative_seen     = 1'b0;
                            ln.fraction_digits   = '0;
                            ln.in_fraction       = 1'b0;
                        end
                        ln.field_index = ln.field_index + 2'd1;
                    end else if (rx_byte == wsfp_pkg::CHAR_MINUS) begin
                        ln.negative_seen = 1'b1;
                    end else if (rx_byte == wsfp_pkg::CHAR_DOT) begin
                        ln.in_fraction = 1'b1;
                    end else if (rx_byte >= wsfp_pkg::CHAR_ZERO &&
                                 rx_byte <= wsfp_pkg::CHAR_NINE) begin
                        dg = wsfp_pkg::add_digit(ln.magnitude, rx_byte[3:0],
                                                 ln.in_fraction, ln.fraction_digits);
                        ln.magnitude       = dg.magnitude;
                        ln.fraction_digits = dg.fraction_digits;
                    end
                end
            end
        end

        // Line close: decide whether the held values are replaced
        accept = ln.keyword_seen && (cnt >= CNT_W'(wsfp_pkg::MIN_LINE_BYTES));
        if (accept) begin
            if (ln.field_index == 2'd0) begin
                hd = '0;
                hs = '0;
            end else begin
                hd = ln.pending_direction;
                hs = wsfp_pkg::signed_value(ln);
            end
        end

        result.direction_milli = hd;
        result.speed_milli     = hs;
        result.updated         = accept;
        result.reading_present = (hd != '0) || (hs != '0);

        line_next       = ln;
        count_next      = cnt;
        held_dir_next   = held_dir_reg;
        held_speed_next = held_speed_reg;
        if (rx_byte == wsfp_pkg::CHAR_NL) begin
            held_dir_next   = hd;
            held_speed_next = hs;
            line_next       = '0;
            count_next      = '0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg       <= '0;
            count_reg      <= '0;
            held_dir_reg   <= '0;
            held_speed_reg <= '0;
        end else if (enable) begin
            line_reg       <= line_next;
            count_reg      <= count_next;
            held_dir_reg   <= held_dir_next;
            held_speed_reg <= held_speed_next;
        end
    end

endmodule

/* rtl/core/wsfp_out_stage.sv */
// ----------------------------------------------------------------------------
// wsfp_out_stage
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module wsfp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wsfp_pkg::result_t  result,
    output logic               load_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wsfp_pkg::result_t  m_result
);

    logic              valid_reg, valid_next;
    wsfp_pkg::result_t data_reg;

    // Free when empty or being drained this cycle
    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule
